// ----- rtl/phase_field_bulk_derivative_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bulk free-energy derivative pipeline.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PHASE_FIELD_BULK_DERIVATIVE_MACROS_SVH
`define PHASE_FIELD_BULK_DERIVATIVE_MACROS_SVH

// Same-cycle implication.
`define PFBD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfbd: check failed");

// Implication after a fixed number of cycles.
`define PFBD_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("pfbd: delayed check failed");

`endif

// ----- rtl/pfbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbd_pkg
// Shared constants, log table and register codes for the bulk derivative.
// ----------------------------------------------------------------------------
package pfbd_pkg;

    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned DATA_W    = 32;
    // width of the concentration words fed to the log unit
    localparam int unsigned XW        = 34;
    localparam int unsigned MUL_LAT   = 4;
    localparam int unsigned LN_LAT    = 5;

    localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [35:0] LN2_Q30 = 36'sd744261118;

    // ln(1 + k/16) in Q0.30
    localparam logic [29:0] LN_TAB [0:16] = '{
        30'd0,         30'd65095192,  30'd126468570, 30'd184522808,
        30'd239598564, 30'd291986604, 30'd341937091, 30'd389666807,
        30'd435364844, 30'd479197128, 30'd521310048, 30'd561833416,
        30'd600882877, 30'd638561895, 30'd674963409, 30'd710171213,
        30'd744261118
    };

    typedef enum logic [2:0] {
        REG_THERMAL = 3'd0,
        REG_EFV     = 3'd1,
        REG_EFG     = 3'd2,
        REG_BARRIER = 3'd3
    } cfg_reg_t;

endpackage

// ----- rtl/pfbd_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbd_delay
// Fixed-length shift line that keeps side operands aligned with the pipeline.
// ----------------------------------------------------------------------------
module pfbd_delay #(
    parameter int unsigned W = 32,
    parameter int unsigned D = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= d;
        for (int k = 1; k < D; k++)
        begin
            pipe_reg[k] <= pipe_reg[k-1];
        end
    end

    assign q = pipe_reg[D-1];

endmodule

// ----- rtl/pfbd_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbd_mul
// Four-stage signed fixed-point multiplier: magnitude, 32x32 partial
// products, accumulate, truncate toward zero and saturate to +-(2^62 - 1).
// ----------------------------------------------------------------------------
module pfbd_mul #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 32
) (
    input  logic               clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [63:0]   p
);

    localparam int unsigned NA = (AW + 31) / 32;
    localparam int unsigned NB = (BW + 31) / 32;
    localparam int unsigned PW = 32 * (NA + NB);
    localparam int unsigned QW = PW - pfbd_pkg::FRAC_BITS;
    localparam int unsigned CW = (QW > 64) ? QW : 64;

    logic [AW-1:0]      abs_a;
    logic [BW-1:0]      abs_b;
    logic [NA*32-1:0]   mag_a_reg;
    logic [NB*32-1:0]   mag_b_reg;
    logic [63:0]        pp_reg [NA][NB];
    logic [PW-1:0]      prod_next;
    logic [PW-1:0]      prod_reg;
    logic               neg1_reg;
    logic               neg2_reg;
    logic               neg3_reg;
    logic [CW-1:0]      q_ext;
    logic [63:0]        q_sat;
    logic signed [63:0] p_next;
    logic signed [63:0] p_reg;

    assign abs_a = a[AW-1] ? $unsigned(-a) : $unsigned(a);
    assign abs_b = b[BW-1] ? $unsigned(-b) : $unsigned(b);

    always_comb
    begin
        prod_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                prod_next = prod_next + (PW'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_comb
    begin
        q_ext = CW'(prod_reg >> pfbd_pkg::FRAC_BITS);
        if (q_ext > CW'(pfbd_pkg::LIM))
        begin
            q_sat = pfbd_pkg::LIM;
        end
        else
        begin
            q_sat = q_ext[63:0];
        end
        p_next = neg3_reg ? -$signed(q_sat) : $signed(q_sat);
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= (NA*32)'(abs_a);
        mag_b_reg <= (NB*32)'(abs_b);
        neg1_reg  <= a[AW-1] ^ b[BW-1];
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= 64'(mag_a_reg[32*i +: 32]) * 64'(mag_b_reg[32*j +: 32]);
            end
        end
        neg2_reg <= neg1_reg;
        prod_reg <= prod_next;
        neg3_reg <= neg2_reg;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/pfbd_ln.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbd_ln
// Five-stage natural log: leading-one search, normalize, table lookup,
// linear interpolation, rescale. A non-positive input gives zero.
// ----------------------------------------------------------------------------
module pfbd_ln (
    input  logic                          clk,
    input  logic signed [pfbd_pkg::XW-1:0] x,
    output logic signed [31:0]            y
);

    localparam int unsigned XW = pfbd_pkg::XW;
    localparam int unsigned SH = 30 - pfbd_pkg::FRAC_BITS;

    logic [5:0]         p_next;
    logic [5:0]         p_reg;
    logic [XW-1:0]      x_reg;
    logic [XW-1:0]      xn;
    logic [29:0]        f_reg;
    logic signed [6:0]  pe;
    logic signed [35:0] ep2_reg;
    logic signed [35:0] ep3_reg;
    logic [4:0]         idx;
    logic [4:0]         idx_hi;
    logic [29:0]        t_hi;
    logic [29:0]        tab_reg;
    logic [25:0]        d_reg;
    logic [25:0]        r_reg;
    logic [51:0]        dr_full;
    logic [25:0]        dr_reg;
    logic signed [36:0] base_reg;
    logic signed [37:0] v;
    logic signed [31:0] y_reg;
    logic [4:0]         pos_reg;

    always_comb
    begin
        p_next = '0;
        for (int k = 0; k < XW; k++)
        begin
            if (x[k])
            begin
                p_next = 6'(k);
            end
        end
    end

    // put the leading one at the top bit; the 30 bits below it are the fraction
    assign xn     = x_reg << (6'(XW - 1) - p_reg);
    assign pe     = $signed({1'b0, p_reg}) - 7'(pfbd_pkg::FRAC_BITS);
    assign idx    = {1'b0, f_reg[29:26]};
    assign idx_hi = idx + 5'd1;
    assign t_hi   = pfbd_pkg::LN_TAB[idx_hi];
    assign dr_full = 52'(d_reg) * 52'(r_reg);
    assign v      = 38'(base_reg) + $signed({12'b0, dr_reg});

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        x_reg    <= x;
        pos_reg  <= {pos_reg[3:0], (!x[XW-1] && (|x))};
        f_reg    <= xn[XW-2 -: 30];
        ep2_reg  <= 36'(pe) * pfbd_pkg::LN2_Q30;
        tab_reg  <= pfbd_pkg::LN_TAB[idx];
        d_reg    <= 26'(t_hi - pfbd_pkg::LN_TAB[idx]);
        r_reg    <= f_reg[25:0];
        ep3_reg  <= ep2_reg;
        dr_reg   <= dr_full[51:26];
        base_reg <= 37'(ep3_reg) + $signed({7'b0, tab_reg});
        // arithmetic shift rounds toward minus infinity
        y_reg    <= pos_reg[3] ? 32'(v >>> SH) : 32'sd0;
    end

    assign y = y_reg;

endmodule

// ----- rtl/phase_field_bulk_derivative.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_field_bulk_derivative
// Bulk free-energy derivative (residual) or its linearization (Jacobian)
// for one quadrature point per item, signed Q8.24, saturated output.
//
//   channel  | signals                                         | dir
//   ---------+-------------------------------------------------+-----
//   command  | start, busy, vacancy_conc, gas_conc,            | in
//            | order_param, shape_value, opcode                |
//   result   | result_valid, derivative, saturated             | out
//   config   | cfg_write, cfg_index, cfg_data                  | in
//
// One item enters per cycle; busy stays low. The delay from an item to
// its result is set by the path through the log units, the entropy
// products and the final products (24 register stages).
// Results stay on the ports for one cycle; the pipeline never stalls.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`include "phase_field_bulk_derivative_macros.svh"

module phase_field_bulk_derivative (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] vacancy_conc,
    input  logic signed [31:0] gas_conc,
    input  logic signed [31:0] order_param,
    input  logic signed [31:0] shape_value,
    input  logic               opcode,
    output logic               result_valid,
    output logic signed [31:0] derivative,
    output logic               saturated,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int unsigned PIPE_DEPTH = 24;
    localparam int unsigned XW = pfbd_pkg::XW;
    localparam int unsigned ML = pfbd_pkg::MUL_LAT;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic signed [31:0] rt_reg, efv_reg, efg_reg, w_reg;

    // stage 0 and 1
    logic signed [31:0] cv0_reg, cg0_reg, u0_reg, phi0_reg;
    logic               op0_reg;
    logic signed [XW-1:0] cv1_reg, cg1_reg, mcv1_reg, omcv1_reg;

    // concentration path
    logic [XW-1:0] cv6, cg6, mcv6, cv11, cg11, omcv11;
    logic signed [31:0] ln_v, ln_g, ln_m;
    logic signed [63:0] xl_v, xl_g, xl_m;
    logic signed [63:0] ent_reg;
    logic signed [63:0] m_rt, m_efv, m_efg, fb;
    logic signed [63:0] fm_reg, fb16_reg, diff_reg;

    // order parameter path
    logic [31:0] u4s, u8s, phi10;
    logic [32:0] phi2_s5;
    logic        op9, op14;
    logic signed [63:0] u2, u3, u4;
    logic [63:0] u2_8, u2_12, u3_12;
    logic signed [63:0] q_reg, t2j, p_reg, pk_reg, t2_reg, t1j;
    logic signed [63:0] poly_reg, t1r_reg, t1_reg;
    logic [63:0] t1_17, t2_17;
    logic signed [63:0] f1, f2, sum_reg;
    logic signed [31:0] derivative_reg;
    logic               saturated_reg;

    assign busy = 1'b0;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg  <= '0;
            efv_reg <= '0;
            efg_reg <= '0;
            w_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (pfbd_pkg::cfg_reg_t'(cfg_index))
                pfbd_pkg::REG_THERMAL: rt_reg  <= cfg_data;
                pfbd_pkg::REG_EFV:     efv_reg <= cfg_data;
                pfbd_pkg::REG_EFG:     efg_reg <= cfg_data;
                pfbd_pkg::REG_BARRIER: w_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start && !busy};
        end
    end

    // ---------------- stages 0 and 1 ----------------
    always_ff @(posedge clk)
    begin
        cv0_reg   <= vacancy_conc;
        cg0_reg   <= gas_conc;
        u0_reg    <= order_param;
        phi0_reg  <= shape_value;
        op0_reg   <= opcode;
        cv1_reg   <= XW'(cv0_reg);
        cg1_reg   <= XW'(cg0_reg);
        mcv1_reg  <= XW'(pfbd_pkg::ONE) - XW'(cv0_reg) - XW'(cg0_reg);
        omcv1_reg <= XW'(pfbd_pkg::ONE) - XW'(cv0_reg);
    end

    // ---------------- mixing free energy ----------------
    pfbd_delay #(.W(XW), .D(pfbd_pkg::LN_LAT)) u_dly_cv6  (.clk(clk), .d(cv1_reg),  .q(cv6));
    pfbd_delay #(.W(XW), .D(pfbd_pkg::LN_LAT)) u_dly_cg6  (.clk(clk), .d(cg1_reg),  .q(cg6));
    pfbd_delay #(.W(XW), .D(pfbd_pkg::LN_LAT)) u_dly_mcv6 (.clk(clk), .d(mcv1_reg), .q(mcv6));
    pfbd_delay #(.W(XW), .D(5)) u_dly_cv11 (.clk(clk), .d(cv6), .q(cv11));
    pfbd_delay #(.W(XW), .D(5)) u_dly_cg11 (.clk(clk), .d(cg6), .q(cg11));
    pfbd_delay #(.W(XW), .D(10)) u_dly_omcv (.clk(clk), .d(omcv1_reg), .q(omcv11));

    pfbd_ln u_ln_v (.clk(clk), .x(cv1_reg),  .y(ln_v));
    pfbd_ln u_ln_g (.clk(clk), .x(cg1_reg),  .y(ln_g));
    pfbd_ln u_ln_m (.clk(clk), .x(mcv1_reg), .y(ln_m));

    pfbd_mul #(.AW(XW), .BW(32)) u_xl_v (.clk(clk), .a(cv6),  .b(ln_v), .p(xl_v));
    pfbd_mul #(.AW(XW), .BW(32)) u_xl_g (.clk(clk), .a(cg6),  .b(ln_g), .p(xl_g));
    pfbd_mul #(.AW(XW), .BW(32)) u_xl_m (.clk(clk), .a(mcv6), .b(ln_m), .p(xl_m));

    always_ff @(posedge clk)
    begin
        ent_reg <= xl_v + xl_g + xl_m;
    end

    pfbd_mul #(.AW(32), .BW(40)) u_m_rt  (.clk(clk), .a(rt_reg),  .b(ent_reg[39:0]), .p(m_rt));
    pfbd_mul #(.AW(32), .BW(32)) u_m_efv (.clk(clk), .a(efv_reg), .b(cv11[31:0]),   .p(m_efv));
    pfbd_mul #(.AW(32), .BW(32)) u_m_efg (.clk(clk), .a(efg_reg), .b(cg11[31:0]),   .p(m_efg));
    pfbd_mul #(.AW(XW), .BW(XW)) u_m_fb  (.clk(clk), .a(omcv11),  .b(omcv11),       .p(fb));

    always_ff @(posedge clk)
    begin
        fm_reg   <= m_rt + m_efv + m_efg;
        fb16_reg <= fb;
        diff_reg <= fb16_reg - fm_reg;
    end

    // ---------------- order parameter polynomials ----------------
    pfbd_delay #(.W(32), .D(ML)) u_dly_u4  (.clk(clk), .d(u0_reg), .q(u4s));
    pfbd_delay #(.W(32), .D(ML)) u_dly_u8  (.clk(clk), .d(u4s),    .q(u8s));
    pfbd_delay #(.W(33), .D(5))  u_dly_phi2 (.clk(clk), .d({phi0_reg, 1'b0}), .q(phi2_s5));
    pfbd_delay #(.W(32), .D(10)) u_dly_phi (.clk(clk), .d(phi0_reg), .q(phi10));
    pfbd_delay #(.W(1),  .D(9))  u_dly_op9 (.clk(clk), .d(op0_reg), .q(op9));
    pfbd_delay #(.W(1),  .D(5))  u_dly_op14 (.clk(clk), .d(op9), .q(op14));

    pfbd_mul #(.AW(32), .BW(32)) u_u2 (.clk(clk), .a(u0_reg),     .b(u0_reg), .p(u2));
    pfbd_mul #(.AW(40), .BW(32)) u_u3 (.clk(clk), .a(u2[39:0]),   .b(u4s),    .p(u3));
    pfbd_mul #(.AW(48), .BW(32)) u_u4 (.clk(clk), .a(u3[47:0]),   .b(u8s),    .p(u4));

    pfbd_delay #(.W(64), .D(ML)) u_dly_u2_8  (.clk(clk), .d(u2),   .q(u2_8));
    pfbd_delay #(.W(64), .D(ML)) u_dly_u2_12 (.clk(clk), .d(u2_8), .q(u2_12));
    pfbd_delay #(.W(64), .D(ML)) u_dly_u3_12 (.clk(clk), .d(u3),   .q(u3_12));

    pfbd_mul #(.AW(33), .BW(44)) u_t2j (.clk(clk), .a(phi2_s5), .b(q_reg[43:0]), .p(t2j));
    pfbd_mul #(.AW(32), .BW(56)) u_t1j (.clk(clk), .a(phi10),   .b(pk_reg[55:0]), .p(t1j));

    always_ff @(posedge clk)
    begin
        q_reg    <= pfbd_pkg::ONE - 64'($signed(u4s)) * 64'sd6 + u2 * 64'sd6;
        p_reg    <= u3 * 64'sd4 - $signed(u2_8) * 64'sd6 + 64'($signed(u8s)) * 64'sd2;
        pk_reg   <= p_reg * 64'sd30;
        // residual weight term equals the Jacobian polynomial
        t2_reg   <= op9 ? t2j : p_reg;
        poly_reg <= u4 - $signed(u3_12) * 64'sd2 + $signed(u2_12);
        t1r_reg  <= poly_reg * 64'sd30;
        t1_reg   <= op14 ? t1j : t1r_reg;
    end

    pfbd_delay #(.W(64), .D(2)) u_dly_t1 (.clk(clk), .d(t1_reg), .q(t1_17));
    pfbd_delay #(.W(64), .D(7)) u_dly_t2 (.clk(clk), .d(t2_reg), .q(t2_17));

    // ---------------- final combination ----------------
    pfbd_mul #(.AW(62), .BW(50)) u_f1 (.clk(clk), .a(t1_17[61:0]), .b(diff_reg[49:0]), .p(f1));
    pfbd_mul #(.AW(32), .BW(52)) u_f2 (.clk(clk), .a(w_reg),       .b(t2_17[51:0]),    .p(f2));

    always_ff @(posedge clk)
    begin
        sum_reg <= f1 + f2;
        if (sum_reg > 64'sd2147483647)
        begin
            derivative_reg <= 32'sh7FFF_FFFF;
            saturated_reg  <= 1'b1;
        end
        else if (sum_reg < -64'sd2147483648)
        begin
            derivative_reg <= 32'sh8000_0000;
            saturated_reg  <= 1'b1;
        end
        else
        begin
            derivative_reg <= sum_reg[31:0];
            saturated_reg  <= 1'b0;
        end
    end

    assign result_valid = vld_reg[PIPE_DEPTH-1];
    assign derivative   = derivative_reg;
    assign saturated    = saturated_reg;

    // ---------------- checks ----------------
    `PFBD_ASSERT_DELAY(a_item_out, start && !busy, PIPE_DEPTH, result_valid)
    `PFBD_ASSERT_DELAY(a_no_phantom, !(start && !busy), PIPE_DEPTH, !result_valid)
    `PFBD_ASSERT_IMPL(a_sat_clip, result_valid && saturated, derivative == 32'sh7FFF_FFFF || derivative == 32'sh8000_0000)
    `PFBD_ASSERT_DELAY(a_ln_nonpos, mcv1_reg[XW-1] || mcv1_reg == '0, 5, ln_m == 32'sd0)

endmodule
